>>> rtl/core/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types and constants of the zero-padded box mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bmf_pkg;

  localparam int KSIZE_W  = 3;
  localparam int IWIDTH_W = 11;
  localparam int IHEIGHT_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } bmf_state_t;

  typedef struct packed {
    logic take;
    logic win_init;
    logic win_read;
    logic div_start;
    logic div_step;
    logic load_out;
  } bmf_cmd_t;

  typedef struct packed {
    logic skip;
    logic due;
    logic win_last;
    logic div_done;
    logic out_free;
  } bmf_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/bmf_if.sv
// ----------------------------------------------------------------------------
// bmf_if
// Request channels of the box mean filter: pixels in, means out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmf_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       is_fill;
  modport source (output valid, output pixel, output is_fill, input ready);
  modport sink (input valid, input pixel, input is_fill, output ready);
endinterface

interface bmf_mean_if;
  logic       valid;
  logic       ready;
  logic [7:0] mean_value;
  logic       end_of_frame;
  modport source (output valid, output mean_value, output end_of_frame, input ready);
  modport sink (input valid, input mean_value, input end_of_frame, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bmf_ctrl.sv
// ----------------------------------------------------------------------------
// bmf_ctrl
// Sequencer: take a request and, when a mean is due, walk the window, divide, hand off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_ctrl
  import bmf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire bmf_stat_t stat,
  output bmf_cmd_t       cmd
);

  bmf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !stat.skip) begin
          cmd.take = 1'b1;
          if (stat.due) begin
            cmd.win_init = 1'b1;
            state_next   = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.win_read = 1'b1;
        if (stat.win_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/bmf_datapath.sv
// ----------------------------------------------------------------------------
// bmf_datapath
// Config registers, position counters, row ring, window sum and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_datapath
  import bmf_pkg::*;
#(
  parameter int MAX_KERNEL = 7,
  parameter int MAX_WIDTH  = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic [7:0]           in_pixel,
  input  wire logic                 in_is_fill,
  input  wire bmf_cmd_t             cmd,
  output bmf_stat_t                 stat,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [7:0]                out_mean,
  output logic                      out_eof
);

  localparam int KW   = $clog2(MAX_KERNEL + 1);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int QW   = WW + IHEIGHT_W + 1;
  localparam int RING = MAX_KERNEL * (MAX_WIDTH + 1);
  localparam int AW   = $clog2(RING);
  localparam int KKW  = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int SW   = 8 + KKW;
  localparam int CW   = $clog2(SW + 1);
  localparam int RW   = IHEIGHT_W + 2;
  localparam int CCW  = WW + 2;

  logic [KSIZE_W-1:0]   ksize;
  logic [IWIDTH_W-1:0]  iwidth;
  logic [IHEIGHT_W-1:0] iheight;

  logic [KW-1:0]        ke, half, dd, km1;
  logic [WW-1:0]        we;
  logic [IHEIGHT_W-1:0] he;
  logic [WW:0]          wp1;
  logic [QW-1:0]        lat, area, dist0_full;
  logic [AW-1:0]        dist0;
  logic [KKW-1:0]       kk;

  logic [QW-1:0]        q;
  logic [AW-1:0]        wp, wp_n;
  logic [WW-1:0]        out_col;
  logic [IHEIGHT_W-1:0] out_row;
  logic                 eof_now, restart;

  logic [7:0]           mem [RING];
  logic [7:0]           rdata;
  logic [AW:0]          diff;
  logic [AW-1:0]        raddr;

  logic [KW-1:0]        wi, wj;
  logic signed [RW-1:0] rr;
  logic signed [CCW-1:0] cc, cc_start;
  logic [AW-1:0]        rowdist, rd_dist;
  logic                 inb, rd_valid, rd_inb;
  logic [SW-1:0]        sum;

  logic [KKW-1:0]       rem;
  logic [SW-1:0]        quo;
  logic [CW-1:0]        div_cnt;
  logic [KKW+1:0]       trial;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ksize   <= KSIZE_W'(3);
      iwidth  <= IWIDTH_W'(1024);
      iheight <= IHEIGHT_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KERNEL_SIZE:  ksize   <= cfg_data[KSIZE_W-1:0];
        CFG_IMAGE_WIDTH:  iwidth  <= cfg_data[IWIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: iheight <= cfg_data[IHEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to the supported range
  always_comb begin
    if (ksize == '0) begin
      ke = KW'(1);
    end else if (int'(ksize) > MAX_KERNEL) begin
      ke = KW'(MAX_KERNEL);
    end else begin
      ke = KW'(ksize);
    end
    if (iwidth == '0) begin
      we = WW'(1);
    end else if (int'(iwidth) > MAX_WIDTH) begin
      we = WW'(MAX_WIDTH);
    end else begin
      we = WW'(iwidth);
    end
    he   = (iheight == '0) ? IHEIGHT_W'(1) : iheight;
    half = ke >> 1;
    km1  = ke - KW'(1);
    dd   = km1 - half;
    wp1  = {1'b0, we} + (WW+1)'(1);
  end

  // Derived frame constants, valid in the cycle after a config write
  always_comb begin
    lat        = QW'(dd) * QW'(wp1);
    area       = QW'(we) * QW'(he);
    dist0_full = QW'(km1) * QW'(wp1);
    kk         = KKW'(ke) * KKW'(ke);
  end
  assign dist0 = dist0_full[AW-1:0];

  assign eof_now = (out_row == he - IHEIGHT_W'(1)) && (out_col == we - WW'(1));
  assign restart = cfg_we || (cmd.load_out && eof_now);
  assign wp_n    = (wp == AW'(RING - 1)) ? '0 : wp + AW'(1);

  // Input and output positions
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      q       <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      if (cmd.take) begin
        q <= q + QW'(1);
      end
      if (cmd.load_out) begin
        if (out_col == we - WW'(1)) begin
          out_col <= '0;
          out_row <= out_row + IHEIGHT_W'(1);
        end else begin
          out_col <= out_col + WW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (cmd.take) begin
      wp <= wp_n;
    end
  end

  // Row ring: read back relative to the newest entry
  assign diff  = {1'b0, wp} - {1'b0, rd_dist};
  assign raddr = diff[AW] ? AW'(diff + (AW+1)'(RING)) : diff[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mem[wp_n] <= (q < area && !in_is_fill) ? in_pixel : 8'd0;
    end
    rdata <= mem[raddr];
  end

  // Window walk
  assign inb = !rr[RW-1] && (rr[RW-2:0] < {1'b0, he}) &&
               !cc[CCW-1] && (cc[CCW-2:0] < {1'b0, we});

  always_ff @(posedge clk) begin
    if (cmd.win_init) begin
      wi       <= '0;
      wj       <= '0;
      rr       <= $signed(RW'(out_row)) - $signed(RW'(half));
      cc       <= $signed(CCW'(out_col)) - $signed(CCW'(half));
      cc_start <= $signed(CCW'(out_col)) - $signed(CCW'(half));
      rowdist  <= dist0;
      rd_dist  <= dist0;
    end else if (cmd.win_read) begin
      if (wj == km1) begin
        wj      <= '0;
        wi      <= wi + KW'(1);
        rr      <= rr + RW'(1);
        cc      <= cc_start;
        rowdist <= rowdist - AW'(we);
        rd_dist <= rowdist - AW'(we);
      end else begin
        wj      <= wj + KW'(1);
        cc      <= cc + CCW'(1);
        rd_dist <= rd_dist - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.win_read;
    end
    rd_inb <= inb;
    if (cmd.win_init) begin
      sum <= '0;
    end else if (rd_valid && rd_inb) begin
      sum <= sum + SW'(rdata);
    end
  end

  // Restoring divider, one quotient bit a cycle
  assign trial = {1'b0, rem, quo[SW-1]} - {2'b00, kk};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem     <= '0;
      quo     <= sum;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + CW'(1);
      if (!trial[KKW+1]) begin
        rem <= trial[KKW-1:0];
        quo <= {quo[SW-2:0], 1'b1};
      end else begin
        rem <= {rem[KKW-2:0], quo[SW-1]};
        quo <= {quo[SW-2:0], 1'b0};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      out_mean <= quo[7:0];
      out_eof  <= eof_now;
    end
  end

  always_comb begin
    stat.skip     = in_is_fill && (q == '0);
    stat.due      = (q >= lat);
    stat.win_last = (wi == km1) && (wj == km1);
    stat.div_done = (div_cnt == CW'(SW));
    stat.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

>>> rtl/core/box_mean_filter_zero_pad.sv
// ----------------------------------------------------------------------------
// box_mean_filter_zero_pad: zero-padded box mean over a raster pixel stream.
// Sequence: an item with no mean leaves the sequencer idle; one with a mean walks
//   the k x k window in the ring, one read a cycle, then runs the SW-bit divider (SW = 14 by default).
// Throughput: one item in work at a time. Reset: control and position counters clear,
//   config returns to kernel 3, 1024 x 1024; the row ring is not cleared.
`default_nettype none

module box_mean_filter_zero_pad
  import bmf_pkg::*;
#(
  parameter int MAX_KERNEL = 7,
  parameter int MAX_WIDTH  = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  bmf_pixel_if.sink                 pixels,
  bmf_mean_if.source                means
);

  bmf_cmd_t  cmd;
  bmf_stat_t stat;
  logic      in_ready;

  // The sequencer owns the request handshake on the pixel side.
  assign pixels.ready = in_ready;

  bmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath holds the output register, so a finished mean may wait while
  // the next pixel request is taken.
  bmf_datapath #(
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_pixel   (pixels.pixel),
    .in_is_fill (pixels.is_fill),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (means.ready),
    .out_valid  (means.valid),
    .out_mean   (means.mean_value),
    .out_eof    (means.end_of_frame)
  );

endmodule

`default_nettype wire

>>> rtl/core/bmf_checker.sv
// ----------------------------------------------------------------------------
// bmf_checker
// Port-level checks of the box mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_mean,
  input wire logic       out_eof
);

  // Hold a stalled mean request.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_mean) && $stable(out_eof))
    else $error("stalled mean request changed");

  // Come out of reset idle, with nothing to deliver.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // A new mean is loaded only while no pixel request is taken.
  a_new_mean: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!(in_valid && in_ready)))
    else $error("mean issued on the cycle of a pixel request");

endmodule

bind box_mean_filter_zero_pad bmf_checker u_bmf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixels.valid),
  .in_ready  (pixels.ready),
  .out_valid (means.valid),
  .out_ready (means.ready),
  .out_mean  (means.mean_value),
  .out_eof   (means.end_of_frame)
);

`default_nettype wire
